// ----- rtl/rdcl_pkg.sv -----
// shared constants, types and tables of the ring detector crystal locator
package rdcl_pkg;

  // coordinate and angle widths
  localparam int COORD_BITS    = 16;
  localparam int ANGLE_STEPS   = 16;
  localparam int CORDIC_GUARD  = 8;
  localparam int CW            = COORD_BITS + CORDIC_GUARD + 2;
  localparam int ANG_BITS      = 32;
  localparam int STEP_BITS     = 5;

  // ring arithmetic widths
  localparam int AZ_BITS       = COORD_BITS + 1;
  localparam int RECIP_BITS    = 24;
  localparam int FRAC_BITS     = 24;
  localparam int PROD_BITS     = AZ_BITS + RECIP_BITS;
  localparam int RING_BITS     = AZ_BITS;
  localparam int RINGS_BITS    = 7;
  localparam int BLOCKS_BITS   = 10;
  localparam int HBH_BITS      = 15;
  localparam int RING_OUT_BITS = 6;
  localparam int INDEX_BITS    = 16;
  localparam int MAX_RING_OUT  = 64;

  // stream widths
  localparam int IN_W  = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W = INDEX_BITS + RING_OUT_BITS + BLOCKS_BITS;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RING_COUNT        = 2'd0,
    REG_BLOCK_COUNT       = 2'd1,
    REG_RING_PITCH_RECIP  = 2'd2,
    REG_HALF_BLOCK_HEIGHT = 2'd3
  } cfg_reg_t;

  localparam logic [RINGS_BITS-1:0]  RST_RING_COUNT  = 7'd24;
  localparam logic [BLOCKS_BITS-1:0] RST_BLOCK_COUNT = 10'd784;
  localparam logic [RECIP_BITS-1:0]  RST_RECIP       = 24'd167772;
  localparam logic [HBH_BITS-1:0]    RST_HALF_HEIGHT = 15'd50;

  // angles on the axes, fractions of a turn
  localparam logic [ANG_BITS-1:0] ANG_ZERO          = 32'h0000_0000;
  localparam logic [ANG_BITS-1:0] ANG_QUARTER       = 32'h4000_0000;
  localparam logic [ANG_BITS-1:0] ANG_HALF          = 32'h8000_0000;
  localparam logic [ANG_BITS-1:0] ANG_THREE_QUARTER = 32'hC000_0000;

  typedef struct packed {
    logic [RINGS_BITS-1:0]  ring_count;
    logic [BLOCKS_BITS-1:0] block_count;
    logic [RECIP_BITS-1:0]  recip;
    logic [HBH_BITS-1:0]    half_height;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ANG_BITS-1:0]  ang;
    logic                 axis;
  } cordic_t;

  // ring computation riding beside the angle pipeline
  typedef struct packed {
    logic [AZ_BITS-1:0]       az;
    logic                     z_neg;
    logic                     z_zero;
    logic [PROD_BITS-1:0]     prod;
    logic [RING_BITS-1:0]     ring;
    logic [RING_OUT_BITS-1:0] ring_out;
    logic                     ring_ok;
  } side_t;

  // arctangent of 2^-i in fractions of a turn
  function automatic logic [ANG_BITS-1:0] atan_turns(input logic [STEP_BITS-1:0] step);
    logic [ANG_BITS-1:0] a;
    case (step)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/rdcl_cordic_stage.sv -----
// one vectoring cordic iteration with its pipeline register
module rdcl_cordic_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic [rdcl_pkg::STEP_BITS-1:0] step,
  input  logic                        valid_in,
  input  rdcl_pkg::cordic_t           data_in,
  input  rdcl_pkg::side_t             side_in,
  output logic                        valid_out,
  output rdcl_pkg::cordic_t           data_out,
  output rdcl_pkg::side_t             side_out
);

  rdcl_pkg::cordic_t      data_next;
  logic signed [rdcl_pkg::CW-1:0] dx;
  logic signed [rdcl_pkg::CW-1:0] dy;

  // rotate toward the x axis, axis points pass unchanged
  always_comb begin
    dx = data_in.y >>> step;
    dy = data_in.x >>> step;
    data_next = data_in;
    if (!data_in.axis) begin
      if (!data_in.y[rdcl_pkg::CW-1]) begin
        data_next.x   = data_in.x + dx;
        data_next.y   = data_in.y - dy;
        data_next.ang = data_in.ang + rdcl_pkg::atan_turns(step);
      end else begin
        data_next.x   = data_in.x - dx;
        data_next.y   = data_in.y + dy;
        data_next.ang = data_in.ang - rdcl_pkg::atan_turns(step);
      end
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      data_out <= data_next;
      side_out <= side_in;
    end
  end

endmodule

// ----- rtl/rdcl_output.sv -----
// block number from the angle, crystal index and output register
module rdcl_output (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [rdcl_pkg::BLOCKS_BITS-1:0]    block_count,
  input  logic                                valid_in,
  input  logic [rdcl_pkg::ANG_BITS-1:0]       ang,
  input  logic [rdcl_pkg::RING_OUT_BITS-1:0]  ring_in,
  input  logic                                ok_in,
  output logic                                ready,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [rdcl_pkg::INDEX_BITS-1:0]     crystal_index,
  output logic [rdcl_pkg::RING_OUT_BITS-1:0]  ring_number,
  output logic [rdcl_pkg::BLOCKS_BITS-1:0]    block_number,
  output logic                                index_valid
);

  localparam int BP_BITS = rdcl_pkg::ANG_BITS + rdcl_pkg::BLOCKS_BITS;
  localparam int CI_BITS = rdcl_pkg::INDEX_BITS + 1;

  logic                                v1;
  logic [rdcl_pkg::BLOCKS_BITS-1:0]    block1;
  logic [rdcl_pkg::RING_OUT_BITS-1:0]  ring1;
  logic                                ok1;
  logic                                en1;
  logic                                en2;
  logic [BP_BITS-1:0]                  block_prod;
  logic [CI_BITS-1:0]                  crystal_next;

  // stage enables
  assign en2   = !m_tvalid || m_tready;
  assign en1   = !v1 || en2;
  assign ready = en1;

  // sector = floor(angle * blocks / 2^32)
  assign block_prod = BP_BITS'(ang) * BP_BITS'(block_count);

  // ring * blocks + block
  assign crystal_next = CI_BITS'(ring1) * CI_BITS'(block_count) + CI_BITS'(block1);

  // valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= valid_in;
      end
      if (en2) begin
        m_tvalid <= v1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en1) begin
      block1 <= block_prod[BP_BITS-1:rdcl_pkg::ANG_BITS];
      ring1  <= ring_in;
      ok1    <= ok_in;
    end
    if (en2) begin
      crystal_index <= crystal_next[rdcl_pkg::INDEX_BITS-1:0];
      ring_number   <= ring1;
      block_number  <= block1;
      index_valid   <= ok1;
    end
  end

endmodule

// ----- rtl/ring_detector_crystal_locator_unit.sv -----
// top level of the ring detector crystal locator
// Maps a hit position (x, y, z) to a crystal index, ring * block_count + block. The block
// takes one hit per clock while the output is not stalled and gives one result per hit, in
// order, through these register stages: one input preparation stage, one register
// stage per cordic iteration of the azimuth angle, the block multiply stage and the output
// register. The ring multiply, rounding and range check run beside the first three cordic
// stages. A stalled output holds the pipeline, bubbles are squeezed out first. Configuration is
// written through the cfg port only while no hit is in flight: a user duty the block does not enforce.
module ring_detector_crystal_locator_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [rdcl_pkg::IN_W-1:0]            s_tdata,   // pos_x, pos_y, pos_z
  // master stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [rdcl_pkg::OUT_W-1:0]           m_tdata,   // crystal_index, ring_number, block_number
  output logic [0:0]                           m_tuser,   // index_valid
  // configuration write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rdcl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rdcl_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int N  = rdcl_pkg::ANGLE_STEPS;
  localparam int CB = rdcl_pkg::COORD_BITS;

  rdcl_pkg::cfg_t    cfg;

  logic signed [CB-1:0]            px;
  logic signed [CB-1:0]            py;
  logic signed [CB-1:0]            pz;
  logic signed [rdcl_pkg::CW-1:0]  xw;
  logic signed [rdcl_pkg::CW-1:0]  yw;
  logic signed [rdcl_pkg::AZ_BITS-1:0] zw;
  rdcl_pkg::cordic_t               c_prep_next;
  rdcl_pkg::side_t                 s_prep_next;

  logic                            v_p;
  logic                            en_p;
  rdcl_pkg::cordic_t               c_p;
  rdcl_pkg::side_t                 s_p;

  logic [N-1:0]                    v_c;
  logic [N-1:0]                    en_c;
  rdcl_pkg::cordic_t               c_q  [N];
  rdcl_pkg::side_t                 s_q  [N];
  rdcl_pkg::side_t                 s_nx [N];

  logic                            out_ready;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ring_count  <= rdcl_pkg::RST_RING_COUNT;
      cfg.block_count <= rdcl_pkg::RST_BLOCK_COUNT;
      cfg.recip       <= rdcl_pkg::RST_RECIP;
      cfg.half_height <= rdcl_pkg::RST_HALF_HEIGHT;
    end else if (cfg_valid) begin
      case (rdcl_pkg::cfg_reg_t'(cfg_index))
        rdcl_pkg::REG_RING_COUNT:
          cfg.ring_count <= cfg_data[rdcl_pkg::RINGS_BITS-1:0];
        rdcl_pkg::REG_BLOCK_COUNT:
          cfg.block_count <= cfg_data[rdcl_pkg::BLOCKS_BITS-1:0];
        rdcl_pkg::REG_RING_PITCH_RECIP:
          cfg.recip <= cfg_data[rdcl_pkg::RECIP_BITS-1:0];
        rdcl_pkg::REG_HALF_BLOCK_HEIGHT:
          cfg.half_height <= cfg_data[rdcl_pkg::HBH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input preparation: axis cases, half-turn fold, guard scaling, |z|
  always_comb begin
    px = s_tdata[CB-1:0];
    py = s_tdata[2*CB-1:CB];
    pz = s_tdata[3*CB-1:2*CB];
    xw = {{(rdcl_pkg::CW-CB){px[CB-1]}}, px} <<< rdcl_pkg::CORDIC_GUARD;
    yw = {{(rdcl_pkg::CW-CB){py[CB-1]}}, py} <<< rdcl_pkg::CORDIC_GUARD;
    zw = {pz[CB-1], pz};

    c_prep_next.axis = 1'b0;
    c_prep_next.ang  = rdcl_pkg::ANG_ZERO;
    c_prep_next.x    = xw;
    c_prep_next.y    = yw;
    if (py == '0) begin
      c_prep_next.axis = 1'b1;
      c_prep_next.ang  = px[CB-1] ? rdcl_pkg::ANG_HALF : rdcl_pkg::ANG_ZERO;
    end else if (px == '0) begin
      c_prep_next.axis = 1'b1;
      c_prep_next.ang  = py[CB-1] ? rdcl_pkg::ANG_THREE_QUARTER : rdcl_pkg::ANG_QUARTER;
    end else if (px[CB-1]) begin
      c_prep_next.x   = -xw;
      c_prep_next.y   = -yw;
      c_prep_next.ang = rdcl_pkg::ANG_HALF;
    end

    s_prep_next          = '0;
    s_prep_next.z_neg    = pz[CB-1];
    s_prep_next.z_zero   = (pz == '0);
    s_prep_next.az       = pz[CB-1] ? unsigned'(-zw) : unsigned'(zw);
  end

  // preparation stage register
  assign en_p     = !v_p || en_c[0];
  assign s_tready = en_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= 1'b0;
    end else if (en_p) begin
      v_p <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_p) begin
      c_p <= c_prep_next;
      s_p <= s_prep_next;
    end
  end

  // cordic pipeline with the ring work carried alongside
  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_stage
      if (i == N - 1) begin : g_last_en
        assign en_c[i] = !v_c[i] || out_ready;
      end else begin : g_mid_en
        assign en_c[i] = !v_c[i] || en_c[i+1];
      end

      if (i == 0) begin : g_mul
        // |z| times the reciprocal ring pitch
        always_comb begin
          s_nx[i]      = s_p;
          s_nx[i].prod = rdcl_pkg::PROD_BITS'(s_p.az) *
                         rdcl_pkg::PROD_BITS'(cfg.recip);
        end
      end else if (i == 1) begin : g_ring
        logic [rdcl_pkg::RING_BITS-1:0] half_rings;
        logic [rdcl_pkg::RING_BITS-1:0] ring_floor;
        logic [rdcl_pkg::PROD_BITS-1:0] prod_rnd;
        logic [rdcl_pkg::RING_BITS-1:0] ring_rnd;
        // floor for even ring counts, rounded with a center ring for odd counts
        always_comb begin
          half_rings = rdcl_pkg::RING_BITS'(cfg.ring_count[rdcl_pkg::RINGS_BITS-1:1]);
          ring_floor = s_q[i-1].prod[rdcl_pkg::PROD_BITS-1:rdcl_pkg::FRAC_BITS];
          prod_rnd   = s_q[i-1].prod +
                       (rdcl_pkg::PROD_BITS'(1) << (rdcl_pkg::FRAC_BITS - 1));
          ring_rnd   = prod_rnd[rdcl_pkg::PROD_BITS-1:rdcl_pkg::FRAC_BITS];
          s_nx[i]    = s_q[i-1];
          if (!cfg.ring_count[0]) begin
            s_nx[i].ring = ring_floor +
                           ((s_q[i-1].z_neg || s_q[i-1].z_zero) ? half_rings : '0);
          end else if (s_q[i-1].az < rdcl_pkg::AZ_BITS'(cfg.half_height)) begin
            s_nx[i].ring = '0;
          end else begin
            s_nx[i].ring = ring_rnd + (s_q[i-1].z_neg ? half_rings : '0);
          end
        end
      end else if (i == 2) begin : g_limit
        logic [rdcl_pkg::RINGS_BITS-1:0] limit;
        logic [rdcl_pkg::RINGS_BITS-1:0] limit_m1;
        // saturate at min(ring_count, 64) - 1
        always_comb begin
          limit    = (cfg.ring_count < rdcl_pkg::RINGS_BITS'(rdcl_pkg::MAX_RING_OUT)) ?
                     cfg.ring_count : rdcl_pkg::RINGS_BITS'(rdcl_pkg::MAX_RING_OUT);
          limit_m1 = (limit == '0) ? '0 : limit - 1'b1;
          s_nx[i]  = s_q[i-1];
          s_nx[i].ring_ok = (s_q[i-1].ring < rdcl_pkg::RING_BITS'(limit));
          s_nx[i].ring_out = s_nx[i].ring_ok ?
                             s_q[i-1].ring[rdcl_pkg::RING_OUT_BITS-1:0] :
                             limit_m1[rdcl_pkg::RING_OUT_BITS-1:0];
        end
      end else begin : g_pass
        assign s_nx[i] = s_q[i-1];
      end

      if (i == 0) begin : g_first
        rdcl_cordic_stage u_stage (
          .clk      (clk),
          .rst      (rst),
          .adv      (en_c[i]),
          .step     (rdcl_pkg::STEP_BITS'(i)),
          .valid_in (v_p),
          .data_in  (c_p),
          .side_in  (s_nx[i]),
          .valid_out(v_c[i]),
          .data_out (c_q[i]),
          .side_out (s_q[i])
        );
      end else begin : g_next
        rdcl_cordic_stage u_stage (
          .clk      (clk),
          .rst      (rst),
          .adv      (en_c[i]),
          .step     (rdcl_pkg::STEP_BITS'(i)),
          .valid_in (v_c[i-1]),
          .data_in  (c_q[i-1]),
          .side_in  (s_nx[i]),
          .valid_out(v_c[i]),
          .data_out (c_q[i]),
          .side_out (s_q[i])
        );
      end
    end
  endgenerate

  // block number, crystal index and output register
  rdcl_output u_output (
    .clk          (clk),
    .rst          (rst),
    .block_count  (cfg.block_count),
    .valid_in     (v_c[N-1]),
    .ang          (c_q[N-1].ang),
    .ring_in      (s_q[N-1].ring_out),
    .ok_in        (s_q[N-1].ring_ok),
    .ready        (out_ready),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .crystal_index(m_tdata[rdcl_pkg::INDEX_BITS-1:0]),
    .ring_number  (m_tdata[rdcl_pkg::INDEX_BITS+rdcl_pkg::RING_OUT_BITS-1:
                           rdcl_pkg::INDEX_BITS]),
    .block_number (m_tdata[rdcl_pkg::OUT_W-1:rdcl_pkg::INDEX_BITS+rdcl_pkg::RING_OUT_BITS]),
    .index_valid  (m_tuser[0])
  );

endmodule

// ----- rtl/rdcl_checker.sv -----
// port-level checks of the crystal locator, bound to the top level
module rdcl_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [rdcl_pkg::OUT_W-1:0]          m_tdata,
  input logic [0:0]                          m_tuser,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [rdcl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input logic [rdcl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int RB = rdcl_pkg::RING_OUT_BITS;
  localparam int IB = rdcl_pkg::INDEX_BITS;
  localparam int CI = IB + 1;

  logic [rdcl_pkg::RINGS_BITS-1:0]  nr;
  logic [rdcl_pkg::BLOCKS_BITS-1:0] nb;
  logic [rdcl_pkg::RINGS_BITS-1:0]  lim;
  logic [RB-1:0]                    ring;
  logic [rdcl_pkg::BLOCKS_BITS-1:0] block;
  logic [CI-1:0]                    crystal;

  // shadow of the ring and block counts
  always_ff @(posedge clk) begin
    if (rst) begin
      nr <= rdcl_pkg::RST_RING_COUNT;
      nb <= rdcl_pkg::RST_BLOCK_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == rdcl_pkg::REG_RING_COUNT) begin
        nr <= cfg_data[rdcl_pkg::RINGS_BITS-1:0];
      end
      if (cfg_index == rdcl_pkg::REG_BLOCK_COUNT) begin
        nb <= cfg_data[rdcl_pkg::BLOCKS_BITS-1:0];
      end
    end
  end

  assign lim     = (nr < rdcl_pkg::RINGS_BITS'(rdcl_pkg::MAX_RING_OUT)) ?
                   nr : rdcl_pkg::RINGS_BITS'(rdcl_pkg::MAX_RING_OUT);
  assign ring    = m_tdata[IB+RB-1:IB];
  assign block   = m_tdata[rdcl_pkg::OUT_W-1:IB+RB];
  assign crystal = CI'(ring) * CI'(nb) + CI'(block);

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // index is built from the ring and block it reports
  a_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[IB-1:0] == crystal[IB-1:0])
    else $error("crystal index does not match ring and block");

  // block lies within the sector count
  a_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (nb == '0) ? (block == '0) : (block < nb))
    else $error("block number out of range");

  // ring stays below the limit and saturates when flagged out of range
  a_ring: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && lim != '0 |->
      (RB+1)'(ring) < (RB+1)'(lim) &&
      (m_tuser[0] || (RB+1)'(ring) == (RB+1)'(lim - 1'b1)))
    else $error("ring number not saturated correctly");

  // an empty output lets input in
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind ring_detector_crystal_locator_unit rdcl_checker u_rdcl_checker (.*);

// ----- tb/tb_top.sv -----
// self-checking testbench of the ring detector crystal locator: directed table, random hits
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rdcl_pkg::*;

  // one result as it leaves the block, {m_tuser, m_tdata}
  typedef struct packed {
    logic                     index_valid;
    logic [BLOCKS_BITS-1:0]   block_number;
    logic [RING_OUT_BITS-1:0] ring_number;
    logic [INDEX_BITS-1:0]    crystal_index;
  } crystal_hit_t;

  // one row of the directed table; hit is used only where typed is set
  typedef struct packed {
    cfg_t                         cfg;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic                         typed;
    crystal_hit_t                 hit;
  } hit_row_t;

  localparam cfg_t CFG_RESET = '{RST_RING_COUNT, RST_BLOCK_COUNT, RST_RECIP, RST_HALF_HEIGHT};
  localparam cfg_t CFG_ODD   = '{7'd5, 10'd8, 24'd167772, 15'd50};
  localparam cfg_t CFG_WIDE  = '{7'd64, 10'd1023, 24'hFFFFFF, 15'h7FFF};
  localparam cfg_t CFG_NULL  = '{7'd0, 10'd0, 24'd0, 15'd0};
  localparam cfg_t CFG_ODD7  = '{7'd7, 10'd100, 24'd335544, 15'd25};
  localparam cfg_t CFG_ONE   = '{7'd1, 10'd1, 24'd0, 15'd0};

  localparam crystal_hit_t NO_HIT = '0;

  // arctangent of 2^-i, fractions of a turn scaled by 2^32
  localparam logic [ANG_BITS-1:0] ARC_STEP [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // directed hits, typed results are {index_valid, block, ring, crystal}
  localparam hit_row_t DIRECTED [25] = '{
    // origin, axes, axial extremes, corners and off-axis points at reset settings
    '{CFG_RESET, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{1'b1, 10'd0, 6'd12, 16'd9408}},
    '{CFG_RESET, 16'sd1000, 16'sd0, 16'sd1, 1'b1, '{1'b1, 10'd0, 6'd0, 16'd0}},
    '{CFG_RESET, 16'sd0, 16'sd1000, 16'sd1, 1'b1, '{1'b1, 10'd196, 6'd0, 16'd196}},
    '{CFG_RESET, -16'sd1000, 16'sd0, 16'sd1, 1'b1, '{1'b1, 10'd392, 6'd0, 16'd392}},
    '{CFG_RESET, 16'sd0, -16'sd1000, 16'sd1, 1'b1, '{1'b1, 10'd588, 6'd0, 16'd588}},
    '{CFG_RESET, 16'sd0, 16'sd0, 16'sd32767, 1'b1, '{1'b0, 10'd0, 6'd23, 16'd18032}},
    '{CFG_RESET, 16'sd0, 16'sd0, 16'sh8000, 1'b1, '{1'b0, 10'd0, 6'd23, 16'd18032}},
    '{CFG_RESET, 16'sd0, 16'sd0, -16'sd1, 1'b1, '{1'b1, 10'd0, 6'd12, 16'd9408}},
    '{CFG_RESET, 16'sd32767, 16'sd32767, 16'sd100, 1'b0, NO_HIT},
    '{CFG_RESET, 16'sh8000, 16'sh8000, -16'sd100, 1'b0, NO_HIT},
    '{CFG_RESET, 16'sd32767, 16'sh8000, 16'sd1100, 1'b0, NO_HIT},
    '{CFG_RESET, 16'sh8000, 16'sd32767, -16'sd1100, 1'b0, NO_HIT},
    '{CFG_RESET, 16'sd1, -16'sd1, 16'sd1199, 1'b0, NO_HIT},
    '{CFG_RESET, -16'sd1, 16'sd1, 16'sd1200, 1'b0, NO_HIT},
    '{CFG_RESET, 16'sd21845, -16'sd10922, -16'sd2345, 1'b0, NO_HIT},
    // odd ring count: center band, rounding edge, negative offset, overflow
    '{CFG_ODD, 16'sd0, 16'sd0, 16'sd49, 1'b1, '{1'b1, 10'd0, 6'd0, 16'd0}},
    '{CFG_ODD, 16'sd0, 16'sd0, -16'sd49, 1'b1, '{1'b1, 10'd0, 6'd0, 16'd0}},
    '{CFG_ODD, 16'sd3, 16'sd4, 16'sd50, 1'b0, NO_HIT},
    '{CFG_ODD, -16'sd3, -16'sd4, 16'sd51, 1'b0, NO_HIT},
    '{CFG_ODD, 16'sd5, 16'sd0, -16'sd51, 1'b0, NO_HIT},
    '{CFG_ODD, 16'sd0, 16'sd0, -16'sd300, 1'b0, NO_HIT},
    // largest settings
    '{CFG_WIDE, 16'sd0, -16'sd5, 16'sh8000, 1'b0, NO_HIT},
    '{CFG_WIDE, 16'sd7, 16'sd7, 16'sd32767, 1'b0, NO_HIT},
    // no rings and no blocks at all
    '{CFG_NULL, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{1'b0, 10'd0, 6'd0, 16'd0}},
    '{CFG_NULL, -16'sd9, 16'sd13, 16'sh8000, 1'b1, '{1'b0, 10'd0, 6'd0, 16'd0}}
  };

  localparam int RANDOM_SETUPS = 5;
  localparam int HITS_PER_SETUP = 52;
  localparam int PIPE_CYCLES = 3 + ANGLE_STEPS;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_W-1:0]          s_tdata = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_W-1:0]         m_tdata;
  logic [0:0]               m_tuser;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = REG_RING_COUNT;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // typed result riding with the transaction on the slave side
  logic         row_typed = 1'b0;
  crystal_hit_t row_hit = '0;

  cfg_t         model_cfg = CFG_RESET;
  crystal_hit_t pending_crystals [$];
  int           mismatch_count = 0;
  int           src_idle_pct = 0;
  int           snk_idle_pct = 0;

  ring_detector_crystal_locator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // azimuth of (px, py) as a fraction of a turn, cordic in vectoring mode
  function automatic logic [ANG_BITS-1:0] azimuth_turns(input longint px, input longint py);
    logic [ANG_BITS-1:0] turns;
    longint              ax;
    longint              ay;
    longint              dx;
    longint              dy;
    int                  step;
    turns = ANG_ZERO;
    if (py == 0) begin
      return (px < 0) ? ANG_HALF : ANG_ZERO;
    end
    if (px == 0) begin
      return (py > 0) ? ANG_QUARTER : ANG_THREE_QUARTER;
    end
    ax = px <<< CORDIC_GUARD;
    ay = py <<< CORDIC_GUARD;
    // left half-plane is turned by half a turn first
    if (ax < 0) begin
      ax = -ax;
      ay = -ay;
      turns = ANG_HALF;
    end
    for (step = 0; step < ANGLE_STEPS && step < 24; step++) begin
      dx = ay >>> step;
      dy = ax >>> step;
      if (ay >= 0) begin
        ax = ax + dx;
        ay = ay - dy;
        turns = turns + ARC_STEP[step];
      end else begin
        ax = ax - dx;
        ay = ay + dy;
        turns = turns - ARC_STEP[step];
      end
    end
    return turns;
  endfunction

  // crystal struck by a hit under settings c
  function automatic crystal_hit_t locate_crystal(input cfg_t c,
                                                  input logic signed [COORD_BITS-1:0] px,
                                                  input logic signed [COORD_BITS-1:0] py,
                                                  input logic signed [COORD_BITS-1:0] pz);
    crystal_hit_t        hit;
    longint              z;
    longint              az;
    longint              prod;
    longint              ring;
    longint              limit;
    logic [ANG_BITS-1:0] turns;
    logic [63:0]         spread;
    logic [31:0]         full_index;
    z = pz;
    az = (z < 0) ? -z : z;
    prod = az * longint'(c.recip);
    // even count floors, odd count rounds with a center band
    if (!c.ring_count[0]) begin
      ring = prod >>> FRAC_BITS;
      if (z <= 0) ring = ring + longint'(c.ring_count) / 2;
    end else if (az < longint'(c.half_height)) begin
      ring = 0;
    end else begin
      ring = (prod + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (z < 0) ring = ring + (longint'(c.ring_count) - 1) / 2;
    end
    // saturate at the ring limit
    limit = (c.ring_count < MAX_RING_OUT) ? longint'(c.ring_count) : MAX_RING_OUT;
    if (ring < limit) begin
      hit.index_valid = 1'b1;
      hit.ring_number = ring[RING_OUT_BITS-1:0];
    end else begin
      hit.index_valid = 1'b0;
      hit.ring_number = (limit != 0) ? RING_OUT_BITS'(limit - 1) : '0;
    end
    // azimuth sector
    turns = azimuth_turns(longint'(px), longint'(py));
    spread = {32'd0, turns} * {54'd0, c.block_count};
    hit.block_number = spread[32 +: BLOCKS_BITS];
    full_index = hit.ring_number * c.block_count + hit.block_number;
    hit.crystal_index = full_index[INDEX_BITS-1:0];
    return hit;
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // settings copy, expectations on accepted hits, result check
  always @(posedge clk) begin
    crystal_hit_t got;
    crystal_hit_t want;
    if (rst) begin
      model_cfg = CFG_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RING_COUNT:        model_cfg.ring_count = cfg_data[RINGS_BITS-1:0];
          REG_BLOCK_COUNT:       model_cfg.block_count = cfg_data[BLOCKS_BITS-1:0];
          REG_RING_PITCH_RECIP:  model_cfg.recip = cfg_data[RECIP_BITS-1:0];
          REG_HALF_BLOCK_HEIGHT: model_cfg.half_height = cfg_data[HBH_BITS-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (row_typed) begin
          pending_crystals.push_back(row_hit);
        end else begin
          pending_crystals.push_back(locate_crystal(model_cfg, s_tdata[0 +: COORD_BITS],
                                                    s_tdata[COORD_BITS +: COORD_BITS],
                                                    s_tdata[2*COORD_BITS +: COORD_BITS]));
        end
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata};
        if (pending_crystals.size() == 0) begin
          $error("unexpected result transaction: %h", got);
          mismatch_count++;
        end else begin
          want = pending_crystals.pop_front();
          if (got.crystal_index !== want.crystal_index) begin
            $error("crystal_index: expected %0d, got %0d", want.crystal_index, got.crystal_index);
            mismatch_count++;
          end
          if (got.ring_number !== want.ring_number) begin
            $error("ring_number: expected %0d, got %0d", want.ring_number, got.ring_number);
            mismatch_count++;
          end
          if (got.block_number !== want.block_number) begin
            $error("block_number: expected %0d, got %0d", want.block_number, got.block_number);
            mismatch_count++;
          end
          if (got.index_valid !== want.index_valid) begin
            $error("index_valid: expected %0d, got %0d", want.index_valid, got.index_valid);
            mismatch_count++;
          end
        end
      end
    end
  end

  // one hit on the slave side, with an occasional gap before it
  task automatic send_hit(input logic signed [COORD_BITS-1:0] px,
                          input logic signed [COORD_BITS-1:0] py,
                          input logic signed [COORD_BITS-1:0] pz,
                          input logic typed, input crystal_hit_t hit);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {pz, py, px};
    row_typed <= typed;
    row_hit <= hit;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // stop sending until every expected result is back
  task automatic drain_hits();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_crystals.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // all four registers back to back
  task automatic write_config(input cfg_t c);
    cfg_reg_t idx;
    idx = REG_RING_COUNT;
    cfg_valid <= 1'b1;
    repeat (4) begin
      cfg_index <= idx;
      case (idx)
        REG_RING_COUNT:        cfg_data <= CFG_DATA_BITS'(c.ring_count);
        REG_BLOCK_COUNT:       cfg_data <= CFG_DATA_BITS'(c.block_count);
        REG_RING_PITCH_RECIP:  cfg_data <= CFG_DATA_BITS'(c.recip);
        REG_HALF_BLOCK_HEIGHT: cfg_data <= CFG_DATA_BITS'(c.half_height);
        default: ;
      endcase
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
  endtask

  // stimulus
  initial begin
    cfg_t                         applied;
    cfg_t                         setup;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    longint                       span;
    int                           zi;
    int                           pick;
    int                           scheme;
    int                           k;
    int                           n;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    applied = CFG_RESET;
    src_idle_pct = 12;
    snk_idle_pct = 64;
    for (k = 0; k < 25; k++) begin
      if (DIRECTED[k].cfg != applied) begin
        drain_hits();
        write_config(DIRECTED[k].cfg);
        applied = DIRECTED[k].cfg;
      end
      send_hit(DIRECTED[k].x, DIRECTED[k].y, DIRECTED[k].z, DIRECTED[k].typed,
               DIRECTED[k].hit);
    end

    // random hits under three idling schemes and several settings each
    for (scheme = 0; scheme < 3; scheme++) begin
      src_idle_pct = (scheme == 0) ? 12 : (scheme == 1) ? 64 : 0;
      snk_idle_pct = (scheme == 0) ? 64 : (scheme == 1) ? 12 : 0;
      for (k = 0; k < RANDOM_SETUPS; k++) begin
        case (k)
          0: setup = CFG_RESET;
          1: setup = CFG_ODD7;
          2: setup = CFG_WIDE;
          3: setup = CFG_ONE;
          default: begin
            setup.ring_count = RINGS_BITS'($urandom_range(1, 64));
            setup.block_count = BLOCKS_BITS'($urandom_range(1, 1023));
            setup.recip = RECIP_BITS'($urandom_range(1024, 400000));
            setup.half_height = HBH_BITS'($urandom_range(0, 600));
          end
        endcase
        drain_hits();
        write_config(setup);
        for (n = 0; n < HITS_PER_SETUP; n++) begin
          // hold off once per scheme until the pipeline is empty
          if (k == 2 && n == HITS_PER_SETUP / 2) drain_hits();
          // transverse position: mostly anywhere, some on an axis, some near the center
          x = COORD_BITS'($urandom);
          y = COORD_BITS'($urandom);
          pick = $urandom_range(99);
          if (pick < 10) begin
            x = '0;
          end else if (pick < 20) begin
            y = '0;
          end else if (pick < 35) begin
            x = COORD_BITS'($urandom_range(16)) - COORD_BITS'(8);
            y = COORD_BITS'($urandom_range(16)) - COORD_BITS'(8);
          end
          // axial position: anywhere, within the rings, or at the center band edge
          pick = $urandom_range(99);
          if (pick < 35) begin
            z = COORD_BITS'($urandom);
          end else if (pick < 85) begin
            span = (setup.recip == 0) ? 32767 :
                   ((longint'(setup.ring_count) + 2) <<< (FRAC_BITS - 1)) /
                   longint'(setup.recip);
            if (span > 32767) span = 32767;
            zi = $urandom_range(int'(span));
            z = ($urandom_range(1) != 0) ? -COORD_BITS'(zi) : COORD_BITS'(zi);
          end else begin
            zi = int'(setup.half_height) + $urandom_range(4) - 2;
            z = ($urandom_range(1) != 0) ? -COORD_BITS'(zi) : COORD_BITS'(zi);
          end
          send_hit(x, y, z, 1'b0, NO_HIT);
        end
      end
    end

    drain_hits();
    repeat (2 * PIPE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ring_detector_crystal_locator_unit] OK");
    end else begin
      $display("[ring_detector_crystal_locator_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("[ring_detector_crystal_locator_unit] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rdcl_pkg.sv
rtl/rdcl_cordic_stage.sv
rtl/rdcl_output.sv
rtl/ring_detector_crystal_locator_unit.sv
rtl/rdcl_checker.sv
tb/tb_top.sv
